// ----- rtl/array_list_free_node_manager_top_defines.svh -----
// ============================================================================
// array_list_free_node_manager_top_defines
// Assertion macros shared by the node pool RTL. Each expects clk and arst_n
// in the scope where it is used.
// ============================================================================
`ifndef ARRAY_LIST_FREE_NODE_MANAGER_TOP_DEFINES_SVH
`define ARRAY_LIST_FREE_NODE_MANAGER_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define ALNFM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ALNFM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/alnfm_pkg.sv -----
// ============================================================================
// alnfm_pkg
// Transaction types, operation and status codes, and the command and status
// bundles between the node pool controller and its datapath.
// ============================================================================
package alnfm_pkg;

	// operation codes
	localparam logic [1:0] FN_ALLOC   = 2'd0;
	localparam logic [1:0] FN_RELEASE = 2'd1;
	localparam logic [1:0] FN_INSERT  = 2'd2;
	localparam logic [1:0] FN_DELETE  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_INVALID  = 2'd2;

	// pointer store read address select
	localparam logic [1:0] RA_FH  = 2'd0;
	localparam logic [1:0] RA_POS = 2'd1;
	localparam logic [1:0] RA_RDA = 2'd2;

	// pointer store write address select
	localparam logic [1:0] WA_POS = 2'd0;
	localparam logic [1:0] WA_Q   = 2'd1;
	localparam logic [1:0] WA_CLR = 2'd2;

	// pointer store write data select
	localparam logic [1:0] WD_FH  = 2'd0;
	localparam logic [1:0] WD_RDA = 2'd1;
	localparam logic [1:0] WD_RDB = 2'd2;
	localparam logic [1:0] WD_Q   = 2'd3;

	// free head load select
	localparam logic [1:0] FH_POS = 2'd0;
	localparam logic [1:0] FH_RDA = 2'd1;
	localparam logic [1:0] FH_Q   = 2'd2;

	// working node load select
	localparam logic Q_FH  = 1'b0;
	localparam logic Q_RDA = 1'b1;

	// result node select
	localparam logic [1:0] NODE_NONE = 2'd0;
	localparam logic [1:0] NODE_POS  = 2'd1;
	localparam logic [1:0] NODE_Q    = 2'd2;

	localparam logic [7:0] NULL_NODE = 8'hFF;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [7:0]  position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [7:0]  node;
		logic signed [31:0] removed_value;
	} rsp_t;

	typedef struct packed {
		logic       capture;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       rdb_en;
		logic       dat_rd_en;
		logic       wr_en;
		logic [1:0] wr_addr_sel;
		logic [1:0] wr_data_sel;
		logic       dat_wr_en;
		logic       clr_step;
		logic       q_ld;
		logic       q_sel;
		logic       fh_ld;
		logic [1:0] fh_sel;
		logic       res_ld;
		logic [1:0] res_status;
		logic [1:0] res_node_sel;
		logic       res_rm;
		logic       out_ld;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       pos_ok;
		logic       fh_ok;
		logic       rda_ok;
		logic       clr_last;
	} sts_t;

endpackage

// ----- rtl/array_list_free_node_manager_top.sv -----
// ============================================================================
// array_list_free_node_manager_top
// Node pool holding singly linked lists in fixed arrays, with a free list
// threaded through the same next-pointer store.
// ============================================================================
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  ------------------------------
//  request   in         req_valid / req_ready  req : func, position, value
//  response  out        rsp_valid / rsp_ready  rsp : status, node, removed_value
//
// One transaction at a time. The spacing between acceptances depends on the operation,
// set by dependent reads and writes through the single write port of the pointer
// store. The response register frees the core at once; completion stalls
// only while it still holds an untaken result. After reset a clearing pass
// initialises both stores, one entry a cycle, with req_ready low.
//
`include "array_list_free_node_manager_top_defines.svh"

module array_list_free_node_manager_top #(
	parameter int NODES = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  alnfm_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output alnfm_pkg::rsp_t rsp
);
	import alnfm_pkg::*;

	// controller and datapath talk only through these bundles
	cmd_t cmd;
	sts_t sts;

	alnfm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// stores sized by NODES; indices carry a null flag above the index bits
	alnfm_dp #(
		.NODES (NODES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

	// a held response must not change under a stall
	`ALNFM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp),
		"response changed while stalled")
	// nothing is accepted while a transaction is still being worked on
	`ALNFM_ASSERT_SAME(a_req_idle, req_ready, !cmd.res_ld && !cmd.wr_en,
		"request ready during pointer work")
	// the clearing pass runs only before the first transaction
	`ALNFM_ASSERT_SAME(a_clear_quiet, cmd.clr_step, !req_ready && !rsp_valid,
		"clearing pass overlaps traffic")

endmodule

// ----- rtl/alnfm_dp.sv -----
// ============================================================================
// alnfm_dp
// Node pool datapath: pointer and data stores, free head, working registers,
// result and output registers, and the post-reset clearing counter.
// ============================================================================
`include "array_list_free_node_manager_top_defines.svh"

module alnfm_dp #(
	parameter int NODES = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  alnfm_pkg::req_t     req,
	input  alnfm_pkg::cmd_t     cmd,
	output alnfm_pkg::sts_t     sts,
	output alnfm_pkg::rsp_t     rsp
);
	import alnfm_pkg::*;

	localparam int IW = $clog2(NODES);
	localparam int NW = IW + 1;                 // top bit flags a null pointer
	localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);
	localparam logic [NW-1:0] NULL_PTR = '1;

	logic [NW-1:0] next_mem [NODES];
	logic [31:0]   data_mem [NODES];

	req_t          req_q;
	logic [NW-1:0] fh_q;
	logic [IW-1:0] clr_q;
	logic [IW-1:0] q_q;
	logic [NW-1:0] rda_q;
	logic [NW-1:0] rdb_q;
	logic [31:0]   rdd_q;
	rsp_t          res_q;
	rsp_t          rsp_q;

	logic [31:0]   pos_ext;
	logic [IW-1:0] pos_idx;
	logic [31:0]   q_ext;
	logic [NW-1:0] clr_next;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	logic [NW-1:0] wr_data;
	logic [IW-1:0] dat_wr_addr;
	logic [31:0]   dat_wr_data;
	logic          clr_mode;

	assign pos_ext  = 32'(req_q.position[6:0]);
	assign pos_idx  = pos_ext[IW-1:0];
	assign q_ext    = 32'(q_q);
	assign clr_next = (clr_q == LAST_IDX) ? NULL_PTR : {1'b0, clr_q + IW'(1)};
	assign clr_mode = (cmd.wr_addr_sel == WA_CLR);

	assign sts.func     = req_q.func;
	assign sts.pos_ok   = !req_q.position[7] && (32'(req_q.position[6:0]) < NODES);
	assign sts.fh_ok    = !fh_q[NW-1];
	assign sts.rda_ok   = !rda_q[NW-1];
	assign sts.clr_last = (clr_q == LAST_IDX);

	assign rsp = rsp_q;

	always_comb begin
		unique case (cmd.rd_sel)
			RA_POS:  rd_addr = pos_idx;
			RA_RDA:  rd_addr = rda_q[IW-1:0];
			default: rd_addr = fh_q[IW-1:0];
		endcase
		unique case (cmd.wr_addr_sel)
			WA_POS:  wr_addr = pos_idx;
			WA_CLR:  wr_addr = clr_q;
			default: wr_addr = q_q;
		endcase
		if (clr_mode) begin
			wr_data = clr_next;
		end else begin
			unique case (cmd.wr_data_sel)
				WD_FH:   wr_data = fh_q;
				WD_RDA:  wr_data = rda_q;
				WD_RDB:  wr_data = rdb_q;
				default: wr_data = {1'b0, q_q};
			endcase
		end
		dat_wr_addr = clr_mode ? clr_q : q_q;
		dat_wr_data = clr_mode ? 32'd0 : req_q.value;
	end

	// stores: one write port each, registered reads
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			next_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rda_q <= next_mem[rd_addr];
		end
		if (cmd.rdb_en) begin
			rdb_q <= next_mem[pos_idx];
		end
		if (cmd.dat_wr_en) begin
			data_mem[dat_wr_addr] <= dat_wr_data;
		end
		if (cmd.dat_rd_en) begin
			rdd_q <= data_mem[rda_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fh_q  <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + IW'(1);
			end
			if (cmd.fh_ld) begin
				unique case (cmd.fh_sel)
					FH_POS:  fh_q <= {1'b0, pos_idx};
					FH_RDA:  fh_q <= rda_q;
					default: fh_q <= {1'b0, q_q};
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.q_ld) begin
			q_q <= (cmd.q_sel == Q_RDA) ? rda_q[IW-1:0] : fh_q[IW-1:0];
		end
		if (cmd.res_ld) begin
			res_q.status <= cmd.res_status;
			unique case (cmd.res_node_sel)
				NODE_POS: res_q.node <= req_q.position;
				NODE_Q:   res_q.node <= q_ext[7:0];
				default:  res_q.node <= NULL_NODE;
			endcase
			res_q.removed_value <= cmd.res_rm ? rdd_q : 32'd0;
		end
		if (cmd.out_ld) begin
			rsp_q <= res_q;
		end
	end

	`ALNFM_ASSERT_SAME(a_pos_write_valid, cmd.wr_en && (cmd.wr_addr_sel == WA_POS),
		sts.pos_ok, "pointer write at an out-of-range position")
	`ALNFM_ASSERT_SAME(a_pop_not_empty, cmd.q_ld && (cmd.q_sel == Q_FH),
		!fh_q[NW-1], "node taken from an empty free list")
	`ALNFM_ASSERT_SAME(a_data_read_valid, cmd.dat_rd_en,
		!rda_q[NW-1], "data read through a null successor")

endmodule

// ----- rtl/alnfm_ctrl.sv -----
// ============================================================================
// alnfm_ctrl
// Node pool controller: clearing pass, operation sequencing over the pointer
// store, and the output register handshake.
// ============================================================================
`include "array_list_free_node_manager_top_defines.svh"

module alnfm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  alnfm_pkg::sts_t sts,
	output alnfm_pkg::cmd_t cmd
);
	import alnfm_pkg::*;

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_CHECK    = 4'd2;
	localparam logic [3:0] S_ALLOC_WB = 4'd3;
	localparam logic [3:0] S_INS_W1   = 4'd4;
	localparam logic [3:0] S_INS_W2   = 4'd5;
	localparam logic [3:0] S_DEL_R2   = 4'd6;
	localparam logic [3:0] S_DEL_W1   = 4'd7;
	localparam logic [3:0] S_DEL_W2   = 4'd8;
	localparam logic [3:0] S_DONE     = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.wr_en       = 1'b1;
				cmd.wr_addr_sel = WA_CLR;
				cmd.dat_wr_en   = 1'b1;
				cmd.clr_step    = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_DONE;
				unique case (sts.func)
					FN_ALLOC: begin
						if (!sts.fh_ok) begin
							cmd.res_ld     = 1'b1;
							cmd.res_status = ST_OVERFLOW;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_FH;
							cmd.q_ld   = 1'b1;
							cmd.q_sel  = Q_FH;
							state_d    = S_ALLOC_WB;
						end
					end
					FN_RELEASE: begin
						cmd.res_ld = 1'b1;
						if (!sts.pos_ok) begin
							cmd.res_status = ST_INVALID;
						end else begin
							cmd.wr_en        = 1'b1;
							cmd.wr_addr_sel  = WA_POS;
							cmd.wr_data_sel  = WD_FH;
							cmd.fh_ld        = 1'b1;
							cmd.fh_sel       = FH_POS;
							cmd.res_status   = ST_OK;
							cmd.res_node_sel = NODE_POS;
						end
					end
					FN_INSERT: begin
						if (!sts.pos_ok) begin
							cmd.res_ld     = 1'b1;
							cmd.res_status = ST_INVALID;
						end else if (!sts.fh_ok) begin
							cmd.res_ld     = 1'b1;
							cmd.res_status = ST_OVERFLOW;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_FH;
							cmd.rdb_en = 1'b1;
							cmd.q_ld   = 1'b1;
							cmd.q_sel  = Q_FH;
							state_d    = S_INS_W1;
						end
					end
					FN_DELETE: begin
						if (!sts.pos_ok) begin
							cmd.res_ld     = 1'b1;
							cmd.res_status = ST_INVALID;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_POS;
							state_d    = S_DEL_R2;
						end
					end
				endcase
			end
			S_ALLOC_WB: begin
				cmd.fh_ld        = 1'b1;
				cmd.fh_sel       = FH_RDA;
				cmd.res_ld       = 1'b1;
				cmd.res_status   = ST_OK;
				cmd.res_node_sel = NODE_Q;
				state_d          = S_DONE;
			end
			S_INS_W1: begin
				// new node inherits the successor of position
				cmd.wr_en       = 1'b1;
				cmd.wr_addr_sel = WA_Q;
				cmd.wr_data_sel = WD_RDB;
				cmd.dat_wr_en   = 1'b1;
				cmd.fh_ld       = 1'b1;
				cmd.fh_sel      = FH_RDA;
				state_d         = S_INS_W2;
			end
			S_INS_W2: begin
				cmd.wr_en        = 1'b1;
				cmd.wr_addr_sel  = WA_POS;
				cmd.wr_data_sel  = WD_Q;
				cmd.res_ld       = 1'b1;
				cmd.res_status   = ST_OK;
				cmd.res_node_sel = NODE_Q;
				state_d          = S_DONE;
			end
			S_DEL_R2: begin
				if (!sts.rda_ok) begin
					cmd.res_ld     = 1'b1;
					cmd.res_status = ST_INVALID;
					state_d        = S_DONE;
				end else begin
					cmd.rd_en     = 1'b1;
					cmd.rd_sel    = RA_RDA;
					cmd.dat_rd_en = 1'b1;
					cmd.q_ld      = 1'b1;
					cmd.q_sel     = Q_RDA;
					state_d       = S_DEL_W1;
				end
			end
			S_DEL_W1: begin
				// bypass the unlinked node
				cmd.wr_en       = 1'b1;
				cmd.wr_addr_sel = WA_POS;
				cmd.wr_data_sel = WD_RDA;
				state_d         = S_DEL_W2;
			end
			S_DEL_W2: begin
				cmd.wr_en        = 1'b1;
				cmd.wr_addr_sel  = WA_Q;
				cmd.wr_data_sel  = WD_FH;
				cmd.fh_ld        = 1'b1;
				cmd.fh_sel       = FH_Q;
				cmd.res_ld       = 1'b1;
				cmd.res_status   = ST_OK;
				cmd.res_node_sel = NODE_Q;
				cmd.res_rm       = 1'b1;
				state_d          = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ALNFM_ASSERT_SAME(a_no_overwrite, cmd.out_ld, !out_valid_q || rsp_ready,
		"result loaded over one not yet taken")
	`ALNFM_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready,
		"second transaction taken while one is in flight")
	`ALNFM_ASSERT_SAME(a_rsp_from_done, $rose(out_valid_q), $past(state_q) == S_DONE,
		"response raised outside completion")

endmodule

// ----- dv/alnfm_pool_checker.sv -----
// ----------------------------------------------------------------------------
// alnfm_pool_checker
// Watches both channels of the node pool. It predicts each result from a
// private copy of the data, next-pointer and free-head state, then compares
// every response, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module alnfm_pool_checker #(
	parameter int NODES = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_ready,
	input  alnfm_pkg::req_t req,
	input  logic            rsp_valid,
	input  logic            rsp_ready,
	input  alnfm_pkg::rsp_t rsp,
	output int              errors,
	output int              pending
);
	import alnfm_pkg::*;

	logic [31:0]       pool_data [NODES];
	logic signed [7:0] pool_next [NODES];
	logic signed [7:0] pool_free_head;
	rsp_t              expected_rsp_q [$];

	function automatic bit index_ok(input logic signed [7:0] i);
		return (i >= 0) && (int'(i) < NODES);
	endfunction

	// one pool operation against the private state
	function automatic rsp_t pool_step(input req_t item);
		rsp_t              r;
		logic signed [7:0] q;
		logic signed [7:0] pos;
		r.status        = ST_OK;
		r.node          = NULL_NODE;
		r.removed_value = '0;
		pos             = item.position;
		unique case (item.func)
			FN_ALLOC: begin
				if (!index_ok(pool_free_head)) begin
					r.status = ST_OVERFLOW;
				end else begin
					q              = pool_free_head;
					pool_free_head = pool_next[q];
					r.node         = q;
				end
			end
			FN_RELEASE: begin
				if (!index_ok(pos)) begin
					r.status = ST_INVALID;
				end else begin
					pool_next[pos] = pool_free_head;
					pool_free_head = pos;
					r.node         = pos;
				end
			end
			FN_INSERT: begin
				if (!index_ok(pos)) begin
					r.status = ST_INVALID;
				end else if (!index_ok(pool_free_head)) begin
					r.status = ST_OVERFLOW;
				end else begin
					q              = pool_free_head;
					pool_free_head = pool_next[q];
					pool_data[q]   = item.value;
					pool_next[q]   = pool_next[pos];
					pool_next[pos] = q;
					r.node         = q;
				end
			end
			default: begin
				if (!index_ok(pos)) begin
					r.status = ST_INVALID;
				end else if (!index_ok(pool_next[pos])) begin
					r.status = ST_INVALID;
				end else begin
					q               = pool_next[pos];
					r.removed_value = pool_data[q];
					pool_next[pos]  = pool_next[q];
					pool_next[q]    = pool_free_head;
					pool_free_head  = q;
					r.node          = q;
				end
			end
		endcase
		return r;
	endfunction

	function automatic void report_field(input string field, input longint exp_v,
		input longint act_v);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
		errors++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				pool_data[i] = '0;
				pool_next[i] = (i == NODES - 1) ? NULL_NODE : 8'(i + 1);
			end
			pool_free_head = '0;
			expected_rsp_q.delete();
			errors  = 0;
			pending <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					$display("%0t: response with none expected, actual status %0d node %0d value %0d",
						$time, rsp.status, rsp.node, rsp.removed_value);
					errors++;
				end else begin
					exp_rsp = expected_rsp_q.pop_front();
					if (rsp.status !== exp_rsp.status)
						report_field("status", exp_rsp.status, rsp.status);
					if (rsp.node !== exp_rsp.node)
						report_field("node", exp_rsp.node, rsp.node);
					if (rsp.removed_value !== exp_rsp.removed_value)
						report_field("removed_value", exp_rsp.removed_value,
							rsp.removed_value);
				end
			end
			if (req_valid && req_ready)
				expected_rsp_q.push_back(pool_step(req));
			pending <= expected_rsp_q.size();
		end
	end

endmodule

// ----- dv/tb_array_list_free_node_manager_top.sv -----
// ----------------------------------------------------------------------------
// tb_array_list_free_node_manager_top
// Stimulus and verdict for the node pool. A short directed run covers every
// operation, the field extremes and the error cases; random phases then fill
// the pool to overflow, drain it and mix operations, with idle gaps on both
// channels. Prediction and comparison live in alnfm_pool_checker.
// ----------------------------------------------------------------------------
module tb_array_list_free_node_manager_top;
	import alnfm_pkg::*;

	localparam int NODES = 128;

	// random phases: fill pushes towards an empty pool, drain unlinks and frees
	typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	int   errors;
	int   pending;

	// sender-side view of which nodes are handed out, used only to aim positions
	int         handed_nodes [$];
	bit         node_out [NODES];
	logic [1:0] funcs_in_flight [$];

	// stretches with no idling on each side
	bit snd_steady = 1'b0;
	bit rcv_steady = 1'b0;

	always #4 clk = ~clk;

	array_list_free_node_manager_top #(.NODES(NODES)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	alnfm_pool_checker #(.NODES(NODES)) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending)
	);

	function automatic int gap_cycles(input bit steady);
		return steady ? 0 : int'($urandom_range(0, 16));
	endfunction

	// Mostly a node known to be handed out, so deletes find successors and
	// releases rarely hit a free node; the rest is anywhere, negatives too.
	function automatic logic signed [7:0] pick_position();
		if (handed_nodes.size() != 0 && $urandom_range(0, 99) < 85)
			return 8'(handed_nodes[$urandom_range(0, handed_nodes.size() - 1)]);
		else if ($urandom_range(0, 1) == 1)
			return 8'($urandom_range(0, NODES - 1));
		else
			return 8'($urandom);
	endfunction

	function automatic logic [1:0] pick_func(input phase_t ph);
		int roll;
		roll = $urandom_range(0, 99);
		unique case (ph)
			PH_FILL: begin
				if (roll < 45)      return FN_ALLOC;
				else if (roll < 90) return FN_INSERT;
				else                return 2'($urandom);
			end
			PH_DRAIN: begin
				if (roll < 45)      return FN_DELETE;
				else if (roll < 85) return FN_RELEASE;
				else                return 2'($urandom);
			end
			default: return 2'($urandom);
		endcase
	endfunction

	// One request transaction: optional idle gap, then hold valid until taken.
	// Valid is lowered only when a gap is drawn, so it is never dropped and
	// raised again within the same step.
	task automatic send_req(input logic [1:0] fn, input logic signed [7:0] pos,
		input logic signed [31:0] val);
		int gap;
		if ($urandom_range(0, 39) == 0)
			snd_steady = !snd_steady;
		gap = gap_cycles(snd_steady);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= '{func: fn, position: pos, value: val};
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	// Keep the handed-out set in step with completed transactions.
	always @(posedge clk) begin : track_nodes
		logic [1:0] fn;
		if (rsp_valid && rsp_ready && funcs_in_flight.size() != 0) begin
			fn = funcs_in_flight.pop_front();
			if (rsp.status == ST_OK && rsp.node >= 0) begin
				if (fn == FN_ALLOC || fn == FN_INSERT) begin
					if (!node_out[rsp.node])
						handed_nodes.push_back(int'(rsp.node));
					node_out[rsp.node] = 1'b1;
				end else if (node_out[rsp.node]) begin
					node_out[rsp.node] = 1'b0;
					for (int k = 0; k < handed_nodes.size(); k++) begin
						if (handed_nodes[k] == int'(rsp.node)) begin
							handed_nodes.delete(k);
							break;
						end
					end
				end
			end
		end
		if (req_valid && req_ready)
			funcs_in_flight.push_back(req.func);
	end

	// Response side: random stalls per transaction, with stretches of none.
	initial begin : rsp_sink
		int stall;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rcv_steady = !rcv_steady;
			stall = gap_cycles(rcv_steady);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// Watchdog: far above the slowest legal run.
	initial begin : watchdog
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		phase_t ph;
		int     phase_len;
		int     random_sent;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every operation, field extremes and the error cases;
		// allocate carries junk position and value, which must be ignored
		send_req(FN_ALLOC,   8'sh80, 32'sh8000_0000);
		send_req(FN_ALLOC,   8'sh7F, 32'shFFFF_FFFF);
		send_req(FN_INSERT,  8'sd0,  32'sh7FFF_FFFF);
		send_req(FN_INSERT,  8'sd2,  32'sh8000_0000);
		// inserting after a node that is still free is carried out literally
		send_req(FN_INSERT,  8'sh7F, 32'shFFFF_FFFF);
		send_req(FN_DELETE,  8'sd0,  32'sh1234_5678);
		send_req(FN_DELETE,  8'sh7F, 32'sd0);
		// last node now has a null successor
		send_req(FN_DELETE,  8'sh7F, 32'sd0);
		send_req(FN_RELEASE, 8'sd1,  32'sh5A5A_A5A5);
		send_req(FN_RELEASE, 8'shFF, 32'sd0);
		send_req(FN_RELEASE, 8'sh80, 32'sd0);
		send_req(FN_RELEASE, 8'sh7F, 32'sd0);
		send_req(FN_INSERT,  8'shFF, 32'sd7);
		send_req(FN_INSERT,  8'sh80, 32'sd7);
		send_req(FN_DELETE,  8'shFF, 32'sd0);
		send_req(FN_DELETE,  8'sh80, 32'sd0);
		send_req(FN_ALLOC,   8'sd0,  32'sd0);
		send_req(FN_ALLOC,   8'sd5,  32'sd9);
		send_req(FN_INSERT,  8'sd0,  32'sd0);
		send_req(FN_INSERT,  8'sd0,  32'shFFFF_FFFF);
		send_req(FN_DELETE,  8'sd0,  32'shDEAD_BEEF);
		// releasing node 1, which an earlier allocate handed out, then pulling it back
		send_req(FN_RELEASE, 8'sd1,  32'sd0);
		send_req(FN_ALLOC,   8'sd0,  32'sd0);

		// random phases; a fill phase is long enough to empty the pool
		random_sent = 0;
		ph          = PH_FILL;
		while (random_sent < 1500) begin
			unique case (ph)
				PH_FILL:  phase_len = $urandom_range(160, 200);
				PH_DRAIN: phase_len = $urandom_range(120, 170);
				default:  phase_len = $urandom_range(80, 120);
			endcase
			repeat (phase_len) begin
				send_req(pick_func(ph), pick_position(), 32'($urandom));
				random_sent++;
			end
			unique case (ph)
				PH_FILL:  ph = PH_DRAIN;
				PH_DRAIN: ph = PH_MIXED;
				default:  ph = PH_FILL;
			endcase
		end
		req_valid <= 1'b0;

		// let the last transaction reach the checker, then drain the responses
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
